FILE: design/sts_pkg.sv
package sts_pkg;

  localparam int DEPTH_DEF = 256;

  localparam int VALUE_W   = 32;
  localparam int POS_IN_W  = 8;
  localparam int POS_OUT_W = 8;
  localparam int SIZE_W    = 9;
  localparam int VAR_W     = 2;
  localparam int REG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam int IN_DATA_W  = POS_IN_W + VALUE_W;
  localparam int OUT_DATA_W = POS_OUT_W;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_VARIANT    = 1'd1;

  localparam logic [VAR_W-1:0] VAR_CLOSED    = 2'd0;
  localparam logic [VAR_W-1:0] VAR_HALF_OPEN = 2'd1;
  localparam logic [VAR_W-1:0] VAR_NEIGHBOR  = 2'd2;
  localparam logic [VAR_W-1:0] VAR_SPARE     = 2'd3;

  typedef logic signed [VALUE_W-1:0] word_t;

endpackage

FILE: design/sorted_table_binary_search.sv
// Channel | Dir | Handshake            | Payload
// in      | in  | in_tvalid/in_tready  | tuser: kind; tdata: position_in, value
// out     | out | out_tvalid/out_tready| tuser: found; tdata: position_out
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A write item is stored when it is accepted in idle. A search is accepted, then runs probes that
// each issue an address, then compare, at most clog2(n+1) probes, then leaves the loop, makes up to
// two final reads and posts the result; the single table memory port, one read per probe,
// orders these steps. No new item is taken until the result is posted.
// Reset clears table_size, variant and control; the table holds nothing until written.
// A stalled result holds the block in its result state; config writes are always taken.
module sorted_table_binary_search #(
  parameter int DEPTH = sts_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sts_pkg::IN_DATA_W-1:0]    in_tdata,  // position_in[7:0], value[39:8]
  input  logic                             in_tuser,  // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sts_pkg::OUT_DATA_W-1:0]   out_tdata, // position_out[7:0]
  output logic                             out_tuser, // found
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sts_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]        cfg_data
);
  import sts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  typedef logic signed [PW-1:0] pos_t;

  logic [2:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [VAR_W-1:0]  variant_r;
  logic [VAR_W-1:0]  var_r, var_nxt;
  pos_t              lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, n_r, n_nxt;
  pos_t              res_pos_r, res_pos_nxt;
  logic              res_found_r, res_found_nxt;
  logic              fin_hi_r, fin_hi_nxt;
  word_t             target_r, target_nxt;
  logic              out_valid_r;
  logic              out_found_r;
  logic [POS_OUT_W-1:0] out_pos_r;
  logic              load_out;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [VALUE_W-1:0] ram_rdata;
  word_t             entry;

  logic              in_acc;
  logic [POS_IN_W-1:0] pos_in;
  word_t             value_in;
  pos_t              n_eff;
  logic              loop_go;
  logic signed [PW:0] mid_sum;
  pos_t              mid_c;

  assign pos_in   = in_tdata[POS_IN_W-1:0];
  assign value_in = word_t'(in_tdata[IN_DATA_W-1:POS_IN_W]);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign entry     = word_t'(ram_rdata);

  assign n_eff = (32'(size_r) > DEPTH) ? PW'(DEPTH) : PW'(size_r);
  assign mid_sum = {lo_r[PW-1], lo_r} + {hi_r[PW-1], hi_r};
  assign mid_c   = pos_t'(mid_sum >>> 1);

  always_comb begin
    case (var_r)
      VAR_HALF_OPEN: loop_go = (lo_r < hi_r);
      VAR_NEIGHBOR:  loop_go = ((lo_r + pos_t'(1)) < hi_r);
      default:       loop_go = (lo_r <= hi_r);
    endcase
  end

  sts_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_tdata[IN_DATA_W-1:POS_IN_W]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    var_nxt       = var_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    n_nxt         = n_r;
    res_pos_nxt   = res_pos_r;
    res_found_nxt = res_found_r;
    fin_hi_nxt    = fin_hi_r;
    target_nxt    = target_r;
    ram_we        = 1'b0;
    ram_addr      = AW'(pos_in);
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == KIND_WRITE) begin
            ram_we = (32'(pos_in) < DEPTH);
          end else begin
            target_nxt    = value_in;
            n_nxt         = n_eff;
            var_nxt       = (variant_r == VAR_SPARE) ? VAR_CLOSED : variant_r;
            lo_nxt        = '0;
            hi_nxt        = (variant_r == VAR_HALF_OPEN) ? n_eff : n_eff - pos_t'(1);
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            fin_hi_nxt    = 1'b0;
            state_nxt     = (n_eff == '0) ? S_DONE : S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (loop_go) begin
          mid_nxt   = mid_c;
          ram_addr  = mid_c[AW-1:0];
          state_nxt = S_CMP;
        end else begin
          ram_addr = lo_r[AW-1:0];
          case (var_r)
            VAR_HALF_OPEN: state_nxt = (lo_r != n_r) ? S_FIN : S_DONE;
            VAR_NEIGHBOR:  state_nxt = S_FIN;
            default:       state_nxt = S_DONE;
          endcase
        end
      end
      S_CMP: begin
        if (entry == target_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r;
          state_nxt     = S_DONE;
        end else begin
          if (entry < target_r) begin
            lo_nxt = (var_r == VAR_NEIGHBOR) ? mid_r : mid_r + pos_t'(1);
          end else begin
            hi_nxt = (var_r == VAR_CLOSED) ? mid_r - pos_t'(1) : mid_r;
          end
          state_nxt = S_LOOP;
        end
      end
      S_FIN: begin
        ram_addr = hi_r[AW-1:0];
        if (entry == target_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = fin_hi_r ? hi_r : lo_r;
          state_nxt     = S_DONE;
        end else if ((var_r == VAR_NEIGHBOR) && !fin_hi_r) begin
          fin_hi_nxt = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      variant_r   <= VAR_CLOSED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TABLE_SIZE: size_r    <= cfg_data[SIZE_W-1:0];
          REG_VARIANT:    variant_r <= cfg_data[VAR_W-1:0];
          default:        ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    var_r       <= var_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    n_r         <= n_nxt;
    res_pos_r   <= res_pos_nxt;
    res_found_r <= res_found_nxt;
    fin_hi_r    <= fin_hi_nxt;
    target_r    <= target_nxt;
    if (load_out) begin
      out_found_r <= res_found_r;
      out_pos_r   <= POS_OUT_W'(res_pos_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_pos_r;

endmodule

FILE: design/sts_ram.sv
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
